// ===== rtl/core/multi_pool_free_list_allocator_top_defines.svh =====
// assertion macros for the multi-pool free list allocator
// used by the controller and datapath; expects clk and rst_n in scope
`ifndef MULTI_POOL_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH
`define MULTI_POOL_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define MPFL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mpfl assertion failed");
`define MPFL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mpfl assertion failed");
`else
`define MPFL_ASSERT_IMP(lbl, ante, cons)
`define MPFL_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/core/mpfl_pkg.sv =====
// shared constants, codes and controller/datapath structs for the allocator
// no dependencies
package mpfl_pkg;

  localparam int NUM_POOL       = 4;
  localparam int SLOTS_PER_POOL = 1024;
  localparam int NUM_CFG        = 4;

  localparam int POOL_W     = (NUM_POOL > 1) ? $clog2(NUM_POOL) : 1;
  localparam int SLOT_W     = $clog2(SLOTS_PER_POOL);
  localparam int LINK_W     = SLOT_W + 1;
  localparam int LINK_AW    = POOL_W + SLOT_W;
  localparam int LINK_DEPTH = 1 << LINK_AW;

  localparam int IN_POOL_W  = 3;
  localparam int IN_SLOT_W  = 10;
  localparam int GPOOL_W    = 2;
  localparam int GSLOT_W    = 10;
  localparam int CNT_W      = 11;
  localparam int TOTAL_W    = 13;
  localparam int SPC_W      = 11;
  localparam int CFG_IDX_W  = 3;

  localparam int CNT_MAX    = 2047;
  localparam int SPC_RESET  = 64;

  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(SLOTS_PER_POOL);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef struct packed {
    logic accept;
    logic exec;
    logic carve_wr;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic pool_bad;
    logic op_free;
    logic head_null;
    logic grow_ok;
    logic carve_last;
    logic out_free;
  } dp_stat_t;

endpackage

// ===== rtl/core/mpfl_in_if.sv =====
// request channel: op, pool and slot with valid/ready
// depends on mpfl_pkg
interface mpfl_in_if import mpfl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  op_t                  op;
  logic [IN_POOL_W-1:0] pool;
  logic [IN_SLOT_W-1:0] slot;

  modport source (output valid, output op, output pool, output slot, input ready);
  modport sink (input valid, input op, input pool, input slot, output ready);
endinterface

// ===== rtl/core/mpfl_out_if.sv =====
// result channel: status, grant and pool counters with valid/ready
// depends on mpfl_pkg
interface mpfl_out_if import mpfl_pkg::*; ();
  logic               valid;
  logic               ready;
  status_t            status;
  logic [GSLOT_W-1:0] granted_slot;
  logic [GPOOL_W-1:0] granted_pool;
  logic [CNT_W-1:0]   pool_allocated;
  logic [CNT_W-1:0]   pool_free;
  logic [CNT_W-1:0]   pool_peak;
  logic [TOTAL_W-1:0] chunk_sum;

  modport source (output valid, output status, output granted_slot, output granted_pool,
                  output pool_allocated, output pool_free, output pool_peak,
                  output chunk_sum, input ready);
  modport sink (input valid, input status, input granted_slot, input granted_pool,
                input pool_allocated, input pool_free, input pool_peak,
                input chunk_sum, output ready);
endinterface

// ===== rtl/core/mpfl_cfg_if.sv =====
// configuration write channel: register index and data with valid/ready
// depends on mpfl_pkg
interface mpfl_cfg_if import mpfl_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [SPC_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/mpfl_ram.sv =====
// generic single-write, single-read ram with registered read data
// no dependencies
module mpfl_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/mpfl_ctrl.sv =====
// allocator sequencer: init carve, accept, execute, chunk carve, link re-read, result
// depends on mpfl_pkg and the assertion macro header
`include "multi_pool_free_list_allocator_top_defines.svh"

module mpfl_ctrl import mpfl_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_EXEC  = 6'b000100,
    S_CARVE = 6'b001000,
    S_RD    = 6'b010000,
    S_RESP  = 6'b100000
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE) || ((state_r == S_RESP) && stat.out_free);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.accept   = accept;
    case (state_r)
      S_INIT: begin
        cmd.carve_wr = 1'b1;
        if (stat.carve_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (!stat.pool_bad && !stat.op_free && stat.head_null && stat.grow_ok) begin
          state_nxt = S_CARVE;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_CARVE: begin
        cmd.carve_wr = 1'b1;
        if (stat.carve_last) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_EXEC;
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = accept ? S_EXEC : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  `MPFL_ASSERT_NXT(a_accept_exec, accept, state_r == S_EXEC)
  `MPFL_ASSERT_IMP(a_load_room, cmd.out_load, stat.out_free)
  `MPFL_ASSERT_NXT(a_carve_reread, (state_r == S_CARVE) && stat.carve_last, state_r == S_RD)

endmodule

// ===== rtl/core/mpfl_dpath.sv =====
// allocator datapath: per-pool heads and counters, link ram, carve counter,
// result register; depends on mpfl_pkg, mpfl_ram and the assertion macro header
`include "multi_pool_free_list_allocator_top_defines.svh"

module mpfl_dpath import mpfl_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  op_t                  in_op,
  input  logic [IN_POOL_W-1:0] in_pool,
  input  logic [IN_SLOT_W-1:0] in_slot,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [SPC_W-1:0]     cfg_data,
  input  logic                 out_ready,
  output logic                 out_valid,
  output status_t              out_status,
  output logic [GSLOT_W-1:0]   out_granted_slot,
  output logic [GPOOL_W-1:0]   out_granted_pool,
  output logic [CNT_W-1:0]     out_pool_allocated,
  output logic [CNT_W-1:0]     out_pool_free,
  output logic [CNT_W-1:0]     out_pool_peak,
  output logic [TOTAL_W-1:0]   out_chunk_sum
);

  // per-pool state
  logic [SPC_W-1:0]   spc_r    [NUM_POOL];
  logic [LINK_W-1:0]  head_r   [NUM_POOL];
  logic [CNT_W-1:0]   free_r   [NUM_POOL];
  logic [CNT_W-1:0]   alloc_r  [NUM_POOL];
  logic [CNT_W-1:0]   peak_r   [NUM_POOL];
  logic [LINK_W-1:0]  carved_r [NUM_POOL];
  logic [CNT_W-1:0]   chunk_r  [NUM_POOL];
  logic [TOTAL_W-1:0] total_r;

  // current request
  op_t                  op_r;
  logic [IN_POOL_W-1:0] pool_r;
  logic [IN_SLOT_W-1:0] slot_r;

  // carve sweep
  logic [SLOT_W-1:0] carve_slot_r;
  logic [SLOT_W-1:0] carve_end_r;
  logic              carve_first_r;

  // pending result
  status_t            status_r;
  logic [GSLOT_W-1:0] gslot_r;
  logic [POOL_W-1:0]  gpool_r;
  logic               out_valid_r;

  logic [POOL_W-1:0]  pidx;
  logic [POOL_W-1:0]  in_pidx;
  logic               pool_bad;
  logic [LINK_W-1:0]  head_cur;
  logic [SPC_W-1:0]   spc_cur;
  logic [CNT_W:0]     grow_sum;
  logic [LINK_W-1:0]  grow_top;
  logic [CNT_W:0]     free_add;
  logic [CNT_W-1:0]   free_grow;
  logic [CNT_W-1:0]   free_inc;
  logic [CNT_W-1:0]   free_dec;
  logic [CNT_W-1:0]   alloc_inc;
  logic [CNT_W-1:0]   alloc_dec;
  logic               head_null;
  logic               grow_ok;
  logic               do_free;
  logic               do_pop;
  logic               do_grow;
  logic               do_oom;

  logic               ram_we;
  logic [LINK_AW-1:0] ram_waddr;
  logic [LINK_W-1:0]  ram_wdata;
  logic [LINK_AW-1:0] ram_raddr;
  logic [LINK_W-1:0]  ram_rdata;

  assign pidx      = pool_r[POOL_W-1:0];
  assign in_pidx   = in_pool[POOL_W-1:0];
  assign pool_bad  = int'(pool_r) >= NUM_POOL;
  assign head_cur  = head_r[pidx];
  assign spc_cur   = spc_r[pidx];
  assign head_null = head_cur == NULL_LINK;
  assign grow_sum  = {1'b0, carved_r[pidx]} + {1'b0, spc_cur};
  assign grow_ok   = (spc_cur != '0) && (int'(grow_sum) <= SLOTS_PER_POOL);
  assign grow_top  = LINK_W'(grow_sum - 1'b1);
  assign free_add  = {1'b0, free_r[pidx]} + {1'b0, spc_cur};
  assign free_grow = (int'(free_add) > CNT_MAX) ? CNT_W'(CNT_MAX) : free_add[CNT_W-1:0];
  assign free_inc  = (int'(free_r[pidx]) == CNT_MAX) ? free_r[pidx] : free_r[pidx] + 1'b1;
  assign free_dec  = (free_r[pidx] == '0) ? free_r[pidx] : free_r[pidx] - 1'b1;
  assign alloc_inc = (int'(alloc_r[pidx]) == CNT_MAX) ? alloc_r[pidx] : alloc_r[pidx] + 1'b1;
  assign alloc_dec = (alloc_r[pidx] == '0) ? alloc_r[pidx] : alloc_r[pidx] - 1'b1;

  assign do_free = cmd.exec && !pool_bad && (op_r == OP_FREE);
  assign do_pop  = cmd.exec && !pool_bad && (op_r == OP_ALLOC) && !head_null;
  assign do_grow = cmd.exec && !pool_bad && (op_r == OP_ALLOC) && head_null && grow_ok;
  assign do_oom  = cmd.exec && !pool_bad && (op_r == OP_ALLOC) && head_null && !grow_ok;

  // link ram: carve writes and free pushes share the write port
  assign ram_we    = do_free || cmd.carve_wr;
  assign ram_waddr = cmd.carve_wr ? {pidx, carve_slot_r} : {pidx, slot_r[SLOT_W-1:0]};
  assign ram_wdata = !cmd.carve_wr ? head_cur :
                     carve_first_r ? NULL_LINK : {1'b0, SLOT_W'(carve_slot_r - 1'b1)};
  // head link is fetched at accept, or again after a carve
  assign ram_raddr = cmd.accept ? {in_pidx, head_r[in_pidx][SLOT_W-1:0]}
                                : {pidx, head_cur[SLOT_W-1:0]};

  mpfl_ram #(
    .W     (LINK_W),
    .DEPTH (LINK_DEPTH)
  ) u_link_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign stat.pool_bad   = pool_bad;
  assign stat.op_free    = op_r == OP_FREE;
  assign stat.head_null  = head_null;
  assign stat.grow_ok    = grow_ok;
  assign stat.carve_last = carve_slot_r == carve_end_r;
  assign stat.out_free   = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NUM_POOL; p++) begin
        spc_r[p]    <= SPC_W'(SPC_RESET);
        head_r[p]   <= (p == 0) ? LINK_W'(SPC_RESET - 1) : NULL_LINK;
        free_r[p]   <= (p == 0) ? CNT_W'(SPC_RESET) : '0;
        alloc_r[p]  <= '0;
        peak_r[p]   <= '0;
        carved_r[p] <= (p == 0) ? LINK_W'(SPC_RESET) : '0;
        chunk_r[p]  <= (p == 0) ? CNT_W'(1) : '0;
      end
      total_r       <= TOTAL_W'(1);
      pool_r        <= '0;
      carve_slot_r  <= '0;
      carve_end_r   <= SLOT_W'(SPC_RESET - 1);
      carve_first_r <= 1'b1;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_valid && (int'(cfg_index) < NUM_CFG) && (int'(cfg_index) < NUM_POOL)) begin
        spc_r[cfg_index[POOL_W-1:0]] <= cfg_data;
      end

      if (cmd.accept) begin
        op_r   <= in_op;
        pool_r <= in_pool;
        slot_r <= in_slot;
      end

      if (do_free) begin
        head_r[pidx]  <= {1'b0, slot_r[SLOT_W-1:0]};
        free_r[pidx]  <= free_inc;
        alloc_r[pidx] <= alloc_dec;
      end

      if (do_pop) begin
        head_r[pidx]  <= ram_rdata;
        free_r[pidx]  <= free_dec;
        alloc_r[pidx] <= alloc_inc;
        if (alloc_inc > peak_r[pidx]) begin
          peak_r[pidx] <= alloc_inc;
        end
      end

      if (do_grow) begin
        head_r[pidx]   <= grow_top;
        carved_r[pidx] <= grow_sum[LINK_W-1:0];
        chunk_r[pidx]  <= chunk_r[pidx] + 1'b1;
        free_r[pidx]   <= free_grow;
        total_r        <= total_r + 1'b1;
        carve_slot_r   <= carved_r[pidx][SLOT_W-1:0];
        carve_end_r    <= grow_top[SLOT_W-1:0];
        carve_first_r  <= 1'b1;
      end

      if (cmd.carve_wr) begin
        carve_first_r <= 1'b0;
        carve_slot_r  <= carve_slot_r + 1'b1;
      end

      if (cmd.exec) begin
        if (pool_bad) begin
          status_r <= ST_IGNORED;
        end else if (do_oom) begin
          status_r <= ST_OOM;
        end else begin
          status_r <= ST_OK;
        end
        gslot_r <= do_pop ? GSLOT_W'(head_cur[SLOT_W-1:0]) : '0;
        gpool_r <= do_pop ? pidx : '0;
      end

      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register, payload only
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status         <= status_r;
      out_granted_slot   <= gslot_r;
      out_granted_pool   <= GPOOL_W'(gpool_r);
      out_pool_allocated <= pool_bad ? '0 : alloc_r[pidx];
      out_pool_free      <= pool_bad ? '0 : free_r[pidx];
      out_pool_peak      <= pool_bad ? '0 : peak_r[pidx];
      out_chunk_sum      <= total_r;
    end
  end

  assign out_valid = out_valid_r;

  `MPFL_ASSERT_NXT(a_grow_total, do_grow, total_r == $past(total_r) + TOTAL_W'(1))
  `MPFL_ASSERT_NXT(a_load_status, cmd.out_load, out_valid_r && (out_status == $past(status_r)))
  `MPFL_ASSERT_NXT(a_carve_step, cmd.carve_wr && !stat.carve_last,
                   carve_slot_r == SLOT_W'($past(carve_slot_r) + 1'b1))

endmodule

// ===== rtl/core/multi_pool_free_list_allocator_top.sv =====
// top level of the four-pool slot allocator with lifo free lists
// depends on mpfl_pkg, the channel interfaces, mpfl_ctrl and mpfl_dpath
//
//   channel  dir  handshake      payload
//   in_if    in   valid/ready    op, pool, slot
//   out_if   out  valid/ready    status, granted_slot, granted_pool, counters
//   cfg_if   in   valid/ready    index, data (slots per chunk, pools 0 to 3)
//
// allocate from a non-empty pool and free each pass through accept, then execute
// an allocate that grows its pool adds a chunk carve (one link write per slot
// on the single link ram write port), a head link re-read, then a second execute
// after reset an init pass links pool 0's first chunk; in_ready stays low meanwhile
// the result register frees the request side: the next beat is taken as the last
// result is loaded, and a stalled result holds the block only in its result state
// cfg_ready is always high

module multi_pool_free_list_allocator_top import mpfl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  mpfl_in_if.sink    in_if,
  mpfl_out_if.source out_if,
  mpfl_cfg_if.sink   cfg_if
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_if.ready = 1'b1;

  mpfl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  mpfl_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_op              (in_if.op),
    .in_pool            (in_if.pool),
    .in_slot            (in_if.slot),
    .cfg_valid          (cfg_if.valid),
    .cfg_index          (cfg_if.index),
    .cfg_data           (cfg_if.data),
    .out_ready          (out_if.ready),
    .out_valid          (out_if.valid),
    .out_status         (out_if.status),
    .out_granted_slot   (out_if.granted_slot),
    .out_granted_pool   (out_if.granted_pool),
    .out_pool_allocated (out_if.pool_allocated),
    .out_pool_free      (out_if.pool_free),
    .out_pool_peak      (out_if.pool_peak),
    .out_chunk_sum      (out_if.chunk_sum)
  );

endmodule
